// ===== design/rvs_pkg.sv =====
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared types, codes and constants of the randomised value set.
// ----------------------------------------------------------------------------
package rvs_pkg;

   // Default number of slots in the value store.
   localparam int CAPACITY_DEF = 256;

   // Widths fixed by the transaction fields.
   localparam int KIND_W   = 2;
   localparam int VALUE_W  = 32;
   localparam int DRAW_W   = 31;
   localparam int COUNT_W  = 9;

   // Operation codes carried in the kind field.
   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

   // Completion status of one transaction.
   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // Request transaction.
   typedef struct packed {
      logic [KIND_W-1:0]         kind;
      logic signed [VALUE_W-1:0] value;
      logic [DRAW_W-1:0]         random_draw;
   } req_type;

   // Result transaction.
   typedef struct packed {
      status_type                status;
      logic signed [VALUE_W-1:0] result_value;
      logic [COUNT_W-1:0]        member_count;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       load_req;
      logic       scan_step;
      logic       rd_last;
      logic       wr_append;
      logic       wr_hole;
      logic       mod_start;
      logic       rd_rem;
      logic       respond;
      logic       sel_result;
      status_type code;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              hit;
      logic              scan_over;
      logic              full;
      logic              empty;
      logic              mod_done;
   } dp_stat_type;

endpackage

// ===== design/rvs_ram.sv =====
// ----------------------------------------------------------------------------
// rvs_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rvs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/rvs_mod_unit.sv =====
// ----------------------------------------------------------------------------
// rvs_mod_unit
// Bit-serial restoring remainder unit: draw modulo member count, one
// dividend bit per cycle.
// ----------------------------------------------------------------------------
module rvs_mod_unit
   import rvs_pkg::*;
#(
   parameter int CW = 9
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DRAW_W-1:0] dividend,
   input  logic [CW-1:0]     divisor,
   output logic              done,
   output logic [CW-1:0]     remainder
);

   localparam int BIT_W = $clog2(DRAW_W);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [BIT_W-1:0]  bit_ff, bit_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic [DRAW_W-1:0] dvd_ff, dvd_in;
   logic [CW:0]       trial;

   // One restoring step: bring down the next bit, subtract if it fits.
   always_comb begin
      trial = {rem_ff, dvd_ff[DRAW_W-1]};
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      if (start) begin
         busy_in = 1'b1;
         bit_in  = BIT_W'(DRAW_W - 1);
         rem_in  = '0;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = CW'(trial - {1'b0, divisor});
         end else begin
            rem_in = CW'(trial);
         end
         dvd_in = {dvd_ff[DRAW_W-2:0], 1'b0};
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== design/rvs_datapath.sv =====
// ----------------------------------------------------------------------------
// rvs_datapath
// Value store, member count, scan index, remainder unit and result register
// of the randomised value set.
// ----------------------------------------------------------------------------
module rvs_datapath
   import rvs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  req_type      req_payload,
   input  ctrl_cmd_type cmd,
   output dp_stat_type  stat,
   output logic         rsp_valid,
   output rsp_type      rsp_payload
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);

   logic [KIND_W-1:0]  kind_ff, kind_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [DRAW_W-1:0]  draw_ff, draw_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      idx_ff, idx_in;
   logic [AW-1:0]      pend_ff, pend_in;
   logic               rd_valid_ff, rd_valid_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic               more;
   logic               hit;
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [VALUE_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_addr;
   logic [VALUE_W-1:0] ram_rd_data;
   logic               mod_done;
   logic [CW-1:0]      mod_rem;

   // Scan bookkeeping: data returned by the RAM belongs to the slot issued
   // in the cycle before.
   assign more = (idx_ff < count_ff);
   assign hit  = rd_valid_ff && (ram_rd_data == value_ff);

   // RAM address and write selection.
   always_comb begin
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[AW-1:0];
      if (cmd.scan_step) begin
         ram_rd_en = more;
      end else if (cmd.rd_last) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = AW'(count_ff - 1'b1);
      end else if (cmd.rd_rem) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = mod_rem[AW-1:0];
      end
      ram_wr_en   = cmd.wr_append || cmd.wr_hole;
      ram_wr_addr = cmd.wr_hole ? pos_ff : AW'(count_ff);
      ram_wr_data = cmd.wr_hole ? ram_rd_data : value_ff;
   end

   // Next values of the working registers.
   always_comb begin
      kind_in      = kind_ff;
      value_in     = value_ff;
      draw_in      = draw_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pos_in       = pos_ff;
      rd_valid_in  = cmd.scan_step && more;
      rsp_valid_in = cmd.respond;
      rsp_in       = rsp_ff;
      if (cmd.load_req) begin
         kind_in  = req_payload.kind;
         value_in = req_payload.value;
         draw_in  = req_payload.random_draw;
         idx_in   = '0;
      end
      if (cmd.scan_step && more) begin
         idx_in  = idx_ff + 1'b1;
         pend_in = idx_ff[AW-1:0];
      end
      if (cmd.scan_step && hit) begin
         pos_in = pend_ff;
      end
      if (cmd.wr_append) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.wr_hole) begin
         count_in = count_ff - 1'b1;
      end
      if (cmd.respond) begin
         rsp_in.status       = cmd.code;
         rsp_in.result_value = cmd.sel_result ? ram_rd_data : '0;
         rsp_in.member_count = COUNT_W'(count_ff);
      end
   end

   // Control state of the datapath.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      value_ff <= value_in;
      draw_ff  <= draw_in;
      idx_ff   <= idx_in;
      pend_ff  <= pend_in;
      pos_ff   <= pos_in;
      rsp_ff   <= rsp_in;
   end

   rvs_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (1 << AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   rvs_mod_unit #(
      .CW (CW)
   ) u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (draw_ff),
      .divisor   (count_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Status towards the controller.
   always_comb begin
      stat.kind      = kind_ff;
      stat.hit       = hit;
      stat.scan_over = !more && !rd_valid_ff;
      stat.full      = (count_ff == CW'(CAPACITY));
      stat.empty     = (count_ff == '0);
      stat.mod_done  = mod_done;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== design/rvs_ctrl.sv =====
// ----------------------------------------------------------------------------
// rvs_ctrl
// Sequencer of the randomised value set: decodes the operation and steps
// the datapath through scan, update, remainder and response.
// ----------------------------------------------------------------------------
module rvs_ctrl
   import rvs_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  dp_stat_type  stat,
   output ctrl_cmd_type cmd
);

   typedef enum logic [8:0] {
      S_IDLE     = 9'b000000001,
      S_DISPATCH = 9'b000000010,
      S_SCAN     = 9'b000000100,
      S_APPEND   = 9'b000001000,
      S_RD_LAST  = 9'b000010000,
      S_WR_HOLE  = 9'b000100000,
      S_MOD      = 9'b001000000,
      S_RD_REM   = 9'b010000000,
      S_RESPOND  = 9'b100000000
   } state_type;

   state_type  state_ff, state_in;
   status_type code_ff, code_in;
   logic       sel_ff, sel_in;

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      sel_in   = sel_ff;
      cmd      = '0;
      cmd.code       = code_ff;
      cmd.sel_result = sel_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               sel_in       = 1'b0;
               code_in      = ST_DONE;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (stat.kind == KIND_INSERT || stat.kind == KIND_REMOVE) begin
               state_in = S_SCAN;
            end else if (stat.kind == KIND_GET) begin
               if (stat.empty) begin
                  code_in  = ST_EMPTY;
                  state_in = S_RESPOND;
               end else begin
                  cmd.mod_start = 1'b1;
                  state_in      = S_MOD;
               end
            end else begin
               state_in = S_RESPOND;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.hit) begin
               if (stat.kind == KIND_INSERT) begin
                  code_in  = ST_MISS;
                  state_in = S_RESPOND;
               end else begin
                  state_in = S_RD_LAST;
               end
            end else if (stat.scan_over) begin
               if (stat.kind == KIND_REMOVE) begin
                  code_in  = ST_MISS;
                  state_in = S_RESPOND;
               end else if (stat.full) begin
                  code_in  = ST_FULL;
                  state_in = S_RESPOND;
               end else begin
                  state_in = S_APPEND;
               end
            end
         end
         S_APPEND: begin
            cmd.wr_append = 1'b1;
            state_in      = S_RESPOND;
         end
         S_RD_LAST: begin
            cmd.rd_last = 1'b1;
            state_in    = S_WR_HOLE;
         end
         S_WR_HOLE: begin
            cmd.wr_hole = 1'b1;
            state_in    = S_RESPOND;
         end
         S_MOD: begin
            if (stat.mod_done) begin
               state_in = S_RD_REM;
            end
         end
         S_RD_REM: begin
            cmd.rd_rem = 1'b1;
            sel_in     = 1'b1;
            state_in   = S_RESPOND;
         end
         S_RESPOND: begin
            cmd.respond = 1'b1;
            state_in    = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_DONE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         sel_ff   <= sel_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ===== design/randomized_value_set.sv =====
// ----------------------------------------------------------------------------
// randomized_value_set
// Set of distinct signed 32-bit values held densely in a RAM, with insert,
// remove and get-random-member operations.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the result has been registered, and the result appears on the
// rsp_ ports for one cycle with rsp_valid high. The receiver cannot stall, so
// it must take every result in that cycle. Insert and remove walk the
// stored members through the single read port of the value store, one slot
// per cycle, and stop at the slot that holds the value. An insert that
// finds the value reports a miss; an insert of an absent value appends it,
// or reports full on a full set. A remove that finds the value fetches the
// last member and fills the hole; a failed remove reports a miss. Get
// random runs a bit-serial remainder unit, one draw bit per cycle, and
// reads the member at the remainder of the draw modulo the member count;
// on an empty set, and for the unused operation code, a transaction goes
// straight from decoding to the response. The store needs no clearing
// after reset: only slots below the member count are ever read.
// ----------------------------------------------------------------------------
module randomized_value_set
   import rvs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_payload,
   output logic    rsp_valid,
   output rsp_type rsp_payload
);

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   rvs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   rvs_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== design/rvs_checker.sv =====
// ----------------------------------------------------------------------------
// rvs_checker
// Port-level checks of the randomised value set, bound to the top level.
// ----------------------------------------------------------------------------
module rvs_checker
   import rvs_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_payload
);

   // An accepted transaction makes the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after an accepted transaction");

   // A result only ever follows a busy period and lasts one cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(busy) && !busy))
      else $error("result strobe outside the end of a transaction");

   // A transaction with a failing status returns a zero result value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status != ST_DONE) |-> (rsp_payload.result_value == '0))
      else $error("non-zero result value with a failing status");

   // An empty report means the set holds no members.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == ST_EMPTY) |-> (rsp_payload.member_count == '0))
      else $error("empty status with a non-zero member count");

   // The member count never exceeds the capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (int'(rsp_payload.member_count) <= CAPACITY))
      else $error("member count beyond capacity");

endmodule

bind randomized_value_set rvs_checker #(.CAPACITY(CAPACITY)) u_rvs_checker (.*);

// ===== tb/tb_randomized_value_set.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_randomized_value_set
// Self-checking testbench for the randomised value set.
// ----------------------------------------------------------------------------
// A directed table opens the run. It covers the empty set, the extreme values,
// duplicates, misses, the unused operation code and the hole left by a
// remove. Random traffic follows: a mixed phase, then a full fill to capacity
// with operations on the full set and a drain back to empty, then a second
// mixed phase. Each reply is compared field by field with the oldest owed
// reply: the table's own for typed rows, else a behavioural mirror's.
// ----------------------------------------------------------------------------
module tb_randomized_value_set;
   import rvs_pkg::*;

   localparam int                CAPACITY    = CAPACITY_DEF;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   // One row of the directed table.
   typedef struct {
      req_type req;
      bit      typed;
      rsp_type want;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_payload = '0;
   logic    rsp_valid;
   rsp_type rsp_payload;

   // Mirror of the set contents, updated as each transaction is accepted.
   logic signed [VALUE_W-1:0] mirror_slots [CAPACITY];
   int                        mirror_count = 0;

   // Replies still owed by the block, oldest first.
   rsp_type replies_due [$];

   dir_row_type dir_rows [$];
   int          failures = 0;
   int          kind_sent [4] = '{default: 0};
   int          status_seen [4] = '{default: 0};
   int          peak_members = 0;
   bit          no_idle = 1'b0;

   randomized_value_set #(
      .CAPACITY(CAPACITY)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_payload(rsp_payload)
   );

   always #1 clock = ~clock;

   // Applies one transaction to the mirror and returns the reply it owes.
   function automatic rsp_type mirror_step(input req_type r);
      rsp_type o;
      int      pos;
      o.status       = ST_DONE;
      o.result_value = '0;
      pos = mirror_count;
      for (int i = mirror_count - 1; i >= 0; i--) begin
         if (mirror_slots[i] == r.value) begin
            pos = i;
         end
      end
      case (r.kind)
         KIND_INSERT: begin
            if (pos < mirror_count) begin
               o.status = ST_MISS;
            end else if (mirror_count >= CAPACITY) begin
               o.status = ST_FULL;
            end else begin
               mirror_slots[mirror_count] = r.value;
               mirror_count++;
            end
         end
         KIND_REMOVE: begin
            if (pos >= mirror_count) begin
               o.status = ST_MISS;
            end else begin
               mirror_slots[pos] = mirror_slots[mirror_count - 1];
               mirror_count--;
            end
         end
         KIND_GET: begin
            if (mirror_count == 0) begin
               o.status = ST_EMPTY;
            end else begin
               o.result_value = mirror_slots[int'(r.random_draw) % mirror_count];
            end
         end
         default: ;
      endcase
      o.member_count = COUNT_W'(mirror_count);
      return o;
   endfunction

   function automatic dir_row_type mk_row(input logic [KIND_W-1:0] kind,
                                          input logic [VALUE_W-1:0] value,
                                          input logic [DRAW_W-1:0] draw,
                                          input bit typed,
                                          input status_type st,
                                          input logic [VALUE_W-1:0] res,
                                          input int cnt);
      dir_row_type row;
      row.req.kind               = kind;
      row.req.value              = value;
      row.req.random_draw        = draw;
      row.typed                  = typed;
      row.want.status            = st;
      row.want.result_value      = res;
      row.want.member_count      = COUNT_W'(cnt);
      return row;
   endfunction

   // Presents one transaction after a random gap and waits until it is taken.
   task automatic drive_item(input req_type r, input bit typed, input rsp_type typed_rsp);
      int      gap;
      rsp_type owed;
      if (kind_sent.sum() % 64 == 0) begin
         no_idle = ($urandom_range(0, 3) == 0);
      end
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      start       <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      owed = mirror_step(r);
      replies_due.push_back(typed ? typed_rsp : owed);
      kind_sent[r.kind]++;
      if (mirror_count > peak_members) begin
         peak_members = mirror_count;
      end
   endtask

   task automatic send(input logic [KIND_W-1:0] kind, input logic [VALUE_W-1:0] value,
                       input logic [DRAW_W-1:0] draw);
      req_type r;
      r.kind        = kind;
      r.value       = value;
      r.random_draw = draw;
      drive_item(r, 1'b0, '0);
   endtask

   // Holds the sender off until every owed reply has come back.
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
   endtask

   // Values biased towards a small pool so that hits are frequent.
   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] edge_vals [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                           32'hFFFF_FFFF, 32'h1};
      case ($urandom_range(0, 9))
         0:       return edge_vals[$urandom_range(0, 4)];
         1, 2:    return $urandom();
         default: return VALUE_W'($urandom_range(0, 47)) - 32'd24;
      endcase
   endfunction

   function automatic logic [DRAW_W-1:0] pick_draw();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return DRAW_W'($urandom());
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] pick_member();
      return mirror_slots[$urandom_range(0, mirror_count - 1)];
   endfunction

   // Random mix of all operations, with both present and absent values.
   task automatic mixed_run(input int n, input int insert_pct);
      int                 roll;
      logic [VALUE_W-1:0] v;
      for (int i = 0; i < n; i++) begin
         roll = $urandom_range(0, 99);
         v    = pick_value();
         if (mirror_count > 0 && $urandom_range(0, 3) == 0) begin
            v = pick_member();
         end
         if (roll < insert_pct) begin
            send(KIND_INSERT, v, pick_draw());
         end else if (roll < insert_pct + 35) begin
            if (mirror_count > 0 && $urandom_range(0, 1) == 0) begin
               v = pick_member();
            end
            send(KIND_REMOVE, v, pick_draw());
         end else if (roll < 95) begin
            send(KIND_GET, $urandom(), pick_draw());
         end else begin
            send(KIND_UNUSED, $urandom(), pick_draw());
         end
      end
   endtask

   // Fills the set to capacity, works on the full set, then drains it.
   task automatic fill_and_drain();
      while (mirror_count < CAPACITY) begin
         if ($urandom_range(0, 7) == 0) begin
            send(KIND_GET, $urandom(), pick_draw());
         end else begin
            send(KIND_INSERT, $urandom(), pick_draw());
         end
      end
      for (int i = 0; i < 12; i++) begin
         case (i % 4)
            0: send(KIND_INSERT, $urandom(), pick_draw());
            1: send(KIND_INSERT, pick_member(), pick_draw());
            2: send(KIND_GET, $urandom(), pick_draw());
            default: send(KIND_UNUSED, $urandom(), pick_draw());
         endcase
      end
      while (mirror_count > 0) begin
         case ($urandom_range(0, 9))
            0:       send(KIND_GET, $urandom(), pick_draw());
            1:       send(KIND_REMOVE, $urandom(), pick_draw());
            default: send(KIND_REMOVE, pick_member(), pick_draw());
         endcase
      end
      send(KIND_GET, $urandom(), pick_draw());
      send(KIND_REMOVE, pick_value(), pick_draw());
   endtask

   // Reply checker: each strobed reply is matched against the oldest owed one.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid) begin
         status_seen[rsp_payload.status]++;
         if (replies_due.size() == 0) begin
            $error("reply with no transaction outstanding");
            failures++;
         end else begin
            want = replies_due.pop_front();
            if (rsp_payload.status !== want.status) begin
               $error("mismatch in status: expected %0d, got %0d",
                      want.status, rsp_payload.status);
               failures++;
            end
            if (rsp_payload.result_value !== want.result_value) begin
               $error("mismatch in result_value: expected %0d, got %0d",
                      want.result_value, rsp_payload.result_value);
               failures++;
            end
            if (rsp_payload.member_count !== want.member_count) begin
               $error("mismatch in member_count: expected %0d, got %0d",
                      want.member_count, rsp_payload.member_count);
               failures++;
            end
         end
      end
   end

   // Stimulus sequence.
   initial begin
      for (int i = 0; i < CAPACITY; i++) begin
         mirror_slots[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table: typed replies where they are obvious.
      dir_rows.push_back(mk_row(KIND_GET,    32'd0,         31'd0,        1, ST_EMPTY, 0, 0));
      dir_rows.push_back(mk_row(KIND_REMOVE, 32'd5,         31'd0,        1, ST_MISS,  0, 0));
      dir_rows.push_back(mk_row(KIND_UNUSED, 32'h7FFF_FFFF, 31'h7FFFFFFF, 1, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_INSERT, 32'h8000_0000, 31'd0,        1, ST_DONE,  0, 1));
      dir_rows.push_back(mk_row(KIND_INSERT, 32'h7FFF_FFFF, 31'd0,        1, ST_DONE,  0, 2));
      dir_rows.push_back(mk_row(KIND_INSERT, 32'h0,         31'd0,        1, ST_DONE,  0, 3));
      dir_rows.push_back(mk_row(KIND_INSERT, 32'hFFFF_FFFF, 31'd0,        1, ST_DONE,  0, 4));
      dir_rows.push_back(mk_row(KIND_INSERT, 32'h8000_0000, 31'd0,        1, ST_MISS,  0, 4));
      dir_rows.push_back(mk_row(KIND_GET,    32'd0,         31'd0,        1, ST_DONE,
                                32'h8000_0000, 4));
      dir_rows.push_back(mk_row(KIND_GET,    32'd0,         31'h7FFFFFFF, 0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_GET,    32'hFFFF_FFFF, 31'd5,        0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_REMOVE, 32'h8000_0000, 31'd0,        1, ST_DONE,  0, 3));
      dir_rows.push_back(mk_row(KIND_GET,    32'd0,         31'd0,        0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_REMOVE, 32'd12345,     31'd0,        1, ST_MISS,  0, 3));
      dir_rows.push_back(mk_row(KIND_REMOVE, 32'hFFFF_FFFF, 31'd0,        0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_UNUSED, 32'h1234_5678, 31'h2AAAAAAA, 0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_INSERT, 32'd1,         31'h55555555, 0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_GET,    32'd0,         31'h40000000, 0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_REMOVE, 32'h7FFF_FFFF, 31'd0,        0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_REMOVE, 32'h0,         31'd0,        0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_REMOVE, 32'd1,         31'd0,        0, ST_DONE,  0, 0));
      dir_rows.push_back(mk_row(KIND_INSERT, 32'h0,         31'd0,        0, ST_DONE,  0, 0));
      foreach (dir_rows[i]) begin
         drive_item(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
      end
      settle();

      // Random traffic, with the sender held off between phases.
      mixed_run(350, 45);
      settle();
      fill_and_drain();
      settle();
      mixed_run(200, 40);
      settle();

      // Allow for a stray reply after the last owed one.
      repeat (CAPACITY + 16) @(posedge clock);
      $display("Covered %0d transactions: %0d insert, %0d remove, %0d get, %0d unused code.",
               kind_sent.sum(), kind_sent[0], kind_sent[1], kind_sent[2], kind_sent[3]);
      $display("Peak membership %0d; replies: %0d done, %0d miss, %0d full, %0d empty.",
               peak_members, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog against a block that stops answering.
   initial begin
      #3000000;
      $display("status: fail");
      $finish;
   end

endmodule

// ===== randomized_value_set.f =====
design/rvs_pkg.sv
design/rvs_ram.sv
design/rvs_mod_unit.sv
design/rvs_datapath.sv
design/rvs_ctrl.sv
design/randomized_value_set.sv
design/rvs_checker.sv
tb/tb_randomized_value_set.sv
